>>> rtl/lchh_pkg.sv
`timescale 1ns / 1ps
package lchh_pkg;

   localparam int TableEntries = 64;
   localparam int IdxBits      = $clog2(TableEntries);
   localparam int ErrBits      = 24;
   localparam int KeyBits      = 64;
   localparam int CountBits    = 32;
   localparam int WidthBits    = 24;
   localparam int ThrBits      = 32;
   localparam int EntryBits    = KeyBits + CountBits + ErrBits;

   localparam logic [WidthBits-1:0] WidthReset = WidthBits'(1024);

   localparam logic CmdCount  = 1'b0;
   localparam logic CmdReport = 1'b1;

   typedef struct packed {
      logic [KeyBits-1:0]   key;
      logic [CountBits-1:0] count;
      logic [ErrBits-1:0]   err;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic idx_clr;
      logic idx_inc;
      logic upd_hit;
      logic upd_miss;
      logic push_res;
      logic ev_chk;
      logic flush;
      logic bucket_adv;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;
      logic idx_last;
      logic qual;
      logic pend_valid;
      logic out_free;
      logic close;
      logic report;
   } status_type;

endpackage

>>> rtl/lchh_if.sv
`timescale 1ns / 1ps
interface lchh_req_if;
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic [lchh_pkg::KeyBits-1:0]   key;
   logic [lchh_pkg::ThrBits-1:0]   threshold;
   modport source (output valid, command, key, threshold, input ready);
   modport sink (input valid, command, key, threshold, output ready);
endinterface

interface lchh_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [lchh_pkg::KeyBits-1:0]   key_out;
   logic [lchh_pkg::CountBits-1:0] count;
   logic [lchh_pkg::ErrBits-1:0]   max_error;
   logic                           table_full;
   logic                           last;
   modport source (output valid, found, key_out, count, max_error, table_full, last,
                   input ready);
   modport sink (input valid, found, key_out, count, max_error, table_full, last,
                 output ready);
endinterface

interface lchh_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lchh_pkg::WidthBits-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> rtl/lchh_ram.sv
`timescale 1ns / 1ps
module lchh_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/lchh_dp.sv
`timescale 1ns / 1ps
module lchh_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  lchh_pkg::cmd_type              cmd,
   output lchh_pkg::status_type           status,
   input  logic                           in_command,
   input  logic [lchh_pkg::KeyBits-1:0]   in_key,
   input  logic [lchh_pkg::ThrBits-1:0]   in_threshold,
   input  logic                           csr_we,
   input  logic [lchh_pkg::WidthBits-1:0] csr_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           out_found,
   output logic [lchh_pkg::KeyBits-1:0]   out_key,
   output logic [lchh_pkg::CountBits-1:0] out_count,
   output logic [lchh_pkg::ErrBits-1:0]   out_err,
   output logic                           out_full,
   output logic                           out_last
);
   localparam int IB = lchh_pkg::IdxBits;
   localparam int EB = lchh_pkg::ErrBits;
   localparam int CB = lchh_pkg::CountBits;
   localparam int KB = lchh_pkg::KeyBits;
   localparam int WB = lchh_pkg::WidthBits;

   logic [WB-1:0] width_ff, width_in;
   logic [WB-1:0] items_ff, items_in;
   logic [EB-1:0] bucket_ff, bucket_in;
   logic [lchh_pkg::TableEntries-1:0] valid_ff, valid_in;
   logic [IB-1:0] idx_ff, idx_in;
   logic          report_ff, report_in;
   logic [KB-1:0] key_ff, key_in;
   logic [CB-1:0] thr_ff, thr_in;
   logic          res_found_ff, res_found_in, res_full_ff, res_full_in;
   logic [KB-1:0] res_key_ff, res_key_in;
   logic [CB-1:0] res_count_ff, res_count_in;
   logic [EB-1:0] res_err_ff, res_err_in;
   logic          pend_valid_ff, pend_valid_in;
   lchh_pkg::entry_type pend_ff, pend_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_found_ff, out_found_in, out_full_ff, out_full_in;
   logic          out_last_ff, out_last_in;
   lchh_pkg::entry_type out_ff, out_in;

   lchh_pkg::entry_type rd, wdata;
   logic          we;
   logic [IB-1:0] waddr, free_idx;
   logic          free_any;
   logic          hit, evict, qual, out_free, close;
   logic [WB-1:0] width_eff, items_next;
   logic [EB-1:0] slack;
   logic [CB:0]   support;

   lchh_ram #(.Width(lchh_pkg::EntryBits), .Depth(lchh_pkg::TableEntries)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(idx_ff), .rdata(rd)
   );

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = lchh_pkg::TableEntries - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IB'(i);
         end
      end
   end

   assign hit        = valid_ff[idx_ff] && (rd.key == key_ff);
   assign slack      = bucket_ff - rd.err;
   assign evict      = valid_ff[idx_ff] && (rd.err <= bucket_ff)
                       && (rd.count <= CB'(slack));
   assign support    = {1'b0, rd.count} + (CB + 1)'(rd.err);
   assign qual       = valid_ff[idx_ff] && !evict && (support >= {1'b0, thr_ff});
   assign out_free   = !out_valid_ff || out_ready;
   assign width_eff  = (width_ff == '0) ? WB'(1) : width_ff;
   assign items_next = items_ff + WB'(1);
   assign close      = items_next >= width_eff;

   always_comb begin
      status.hit        = hit;
      status.idx_last   = (idx_ff == IB'(lchh_pkg::TableEntries - 1));
      status.qual       = qual;
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
      status.close      = close;
      status.report     = report_ff;
   end

   always_comb begin
      width_in      = csr_we ? csr_data : width_ff;
      items_in      = items_ff;
      bucket_in     = bucket_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      report_in     = report_ff;
      key_in        = key_ff;
      thr_in        = thr_ff;
      res_found_in  = res_found_ff;
      res_full_in   = res_full_ff;
      res_key_in    = res_key_ff;
      res_count_in  = res_count_ff;
      res_err_in    = res_err_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_found_in  = out_found_ff;
      out_full_in   = out_full_ff;
      out_last_in   = out_last_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      we            = 1'b0;
      waddr         = idx_ff;
      wdata         = rd;

      if (cmd.capture) begin
         report_in = (in_command == lchh_pkg::CmdReport);
         key_in    = in_key;
         // raise a low nonzero threshold to the current bucket
         thr_in    = (in_threshold != '0 && in_threshold < CB'(bucket_ff))
                     ? CB'(bucket_ff) : in_threshold;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + IB'(1);
      end
      if (cmd.upd_hit) begin
         we           = 1'b1;
         wdata.count  = (rd.count == '1) ? rd.count : rd.count + CB'(1);
         res_found_in = 1'b1;
         res_full_in  = 1'b0;
         res_key_in   = key_ff;
         res_count_in = wdata.count;
         res_err_in   = rd.err;
      end
      if (cmd.upd_miss) begin
         res_key_in = key_ff;
         if (free_any) begin
            we                 = 1'b1;
            waddr              = free_idx;
            wdata.key          = key_ff;
            wdata.count        = CB'(1);
            wdata.err          = bucket_ff - EB'(1);
            valid_in[free_idx] = 1'b1;
            res_found_in       = 1'b1;
            res_full_in        = 1'b0;
            res_count_in       = CB'(1);
            res_err_in         = wdata.err;
         end else begin
            res_found_in = 1'b0;
            res_full_in  = 1'b1;
            res_count_in = '0;
            res_err_in   = '0;
         end
      end
      if (cmd.push_res) begin
         out_valid_in  = 1'b1;
         out_found_in  = res_found_ff;
         out_full_in   = res_full_ff;
         out_last_in   = 1'b1;
         out_in.key    = res_key_ff;
         out_in.count  = res_count_ff;
         out_in.err    = res_err_ff;
         items_in      = close ? '0 : items_next;
      end
      if (cmd.ev_chk) begin
         if (evict) begin
            valid_in[idx_ff] = 1'b0;
         end
         if (report_ff && qual) begin
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_found_in = 1'b1;
               out_full_in  = 1'b0;
               out_last_in  = 1'b0;
               out_in       = pend_ff;
            end
            pend_valid_in = 1'b1;
            pend_in       = rd;
         end
      end
      if (cmd.flush) begin
         out_valid_in  = 1'b1;
         out_found_in  = pend_valid_ff;
         out_full_in   = 1'b0;
         out_last_in   = 1'b1;
         out_in        = pend_valid_ff ? pend_ff : '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.bucket_adv && bucket_ff != '1) begin
         bucket_in = bucket_ff + EB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= lchh_pkg::WidthReset;
         items_ff      <= '0;
         bucket_ff     <= EB'(1);
         valid_ff      <= '0;
         idx_ff        <= '0;
         report_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         items_ff      <= items_in;
         bucket_ff     <= bucket_in;
         valid_ff      <= valid_in;
         idx_ff        <= idx_in;
         report_ff     <= report_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      thr_ff       <= thr_in;
      res_found_ff <= res_found_in;
      res_full_ff  <= res_full_in;
      res_key_ff   <= res_key_in;
      res_count_ff <= res_count_in;
      res_err_ff   <= res_err_in;
      pend_ff      <= pend_in;
      out_found_ff <= out_found_in;
      out_full_ff  <= out_full_in;
      out_last_ff  <= out_last_in;
      out_ff       <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_found = out_found_ff;
   assign out_key   = out_ff.key;
   assign out_count = out_ff.count;
   assign out_err   = out_ff.err;
   assign out_full  = out_full_ff;
   assign out_last  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_res || cmd.flush) |-> out_free)
      else $error("result pushed into occupied output register");
   a_bucket_nonzero: assert property (@(posedge clock) disable iff (reset)
      bucket_ff != '0)
      else $error("bucket index reached zero");
   a_insert_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.upd_miss && free_any) |=> valid_ff[$past(free_idx)])
      else $error("inserted slot not marked valid");
`endif
endmodule

>>> rtl/lchh_ctrl.sv
`timescale 1ns / 1ps
module lchh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_ready,
   input  lchh_pkg::status_type status,
   output lchh_pkg::cmd_type    cmd
);
   localparam logic [2:0] SIdle   = 3'd0;
   localparam logic [2:0] SLkRd   = 3'd1;
   localparam logic [2:0] SLkCk   = 3'd2;
   localparam logic [2:0] SCntOut = 3'd3;
   localparam logic [2:0] SEvRd   = 3'd4;
   localparam logic [2:0] SEvCk   = 3'd5;
   localparam logic [2:0] SFlush  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == SIdle);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         SIdle: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = (req_command == lchh_pkg::CmdReport) ? SEvRd : SLkRd;
            end
         end
         SLkRd: state_in = SLkCk;
         SLkCk: begin
            if (status.hit) begin
               cmd.upd_hit = 1'b1;
               state_in    = SCntOut;
            end else if (status.idx_last) begin
               cmd.upd_miss = 1'b1;
               state_in     = SCntOut;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = SLkRd;
            end
         end
         SCntOut: begin
            if (status.out_free) begin
               cmd.push_res = 1'b1;
               if (status.close) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = SEvRd;
               end else begin
                  state_in = SIdle;
               end
            end
         end
         SEvRd: state_in = SEvCk;
         SEvCk: begin
            if (!(status.report && status.qual && status.pend_valid && !status.out_free)) begin
               cmd.ev_chk = 1'b1;
               if (!status.idx_last) begin
                  cmd.idx_inc = 1'b1;
                  state_in    = SEvRd;
               end else if (status.report) begin
                  state_in = SFlush;
               end else begin
                  cmd.bucket_adv = 1'b1;
                  state_in       = SIdle;
               end
            end
         end
         SFlush: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = SIdle;
            end
         end
         default: state_in = SIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.upd_hit, cmd.upd_miss, cmd.push_res, cmd.ev_chk, cmd.flush}) <= 1)
      else $error("more than one datapath step in a cycle");
   a_no_inc_clr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.idx_inc && cmd.idx_clr))
      else $error("slot index both cleared and advanced");
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff != SIdle)
      else $error("controller stayed idle after accepting a word");
`endif
endmodule

>>> rtl/lossy_counting_heavy_hitters_core.sv
`timescale 1ns / 1ps
// Lossy-counting frequent-key tracker with a 64-slot table held in one RAM
// (key, count, error per slot) plus a flop valid bit per slot. A count word
// scans the slots in order, reading then checking each slot, and stops at
// the first key match; a miss runs the full table and inserts into the
// lowest free slot or reports table_full. Every bucket_width counted words
// the bucket closes and an eviction sweep of the table follows before the
// next word is taken. A report word runs the same sweep, emitting each
// qualifying entry in slot order as it goes (one result a slot at most,
// last set on the final one, or one empty result), and may stall on the
// output. The rate is set by the single RAM read port walking the table.
// The csr_ channel writes bucket_width at any time and is always ready;
// write it only while the block is idle.
module lossy_counting_heavy_hitters_core (
   input logic       clock,
   input logic       reset,
   lchh_req_if.sink  req_chan,
   lchh_rsp_if.source rsp_chan,
   lchh_csr_if.sink  csr_chan
);
   lchh_pkg::cmd_type    cmd;
   lchh_pkg::status_type status;

   assign csr_chan.ready = 1'b1;

   // hold sequencing in the controller, all storage in the datapath
   lchh_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_command(req_chan.command),
      .req_ready(req_chan.ready), .status(status), .cmd(cmd)
   );

   lchh_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .in_command(req_chan.command), .in_key(req_chan.key),
      .in_threshold(req_chan.threshold),
      .csr_we(csr_chan.valid), .csr_data(csr_chan.data),
      .out_valid(rsp_chan.valid), .out_ready(rsp_chan.ready),
      .out_found(rsp_chan.found), .out_key(rsp_chan.key_out),
      .out_count(rsp_chan.count), .out_err(rsp_chan.max_error),
      .out_full(rsp_chan.table_full), .out_last(rsp_chan.last)
   );
endmodule
